@@ design/sun_pointing_pd_attitude_law_top_macros.svh @@
// Assertion helpers for the sun-pointing attitude law. They expect clk and rst in scope.
`ifndef SUN_POINTING_PD_ATTITUDE_LAW_TOP_MACROS_SVH
`define SUN_POINTING_PD_ATTITUDE_LAW_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sppd_pkg.sv @@
`default_nettype none

package sppd_pkg;

  localparam int COUNT_W     = 10;
  localparam int RATE_W      = 32;
  localparam int GAIN_W      = 32;
  localparam int SUN_W       = 16;
  localparam int SUNY_W      = 15;
  localparam int TORQUE_W    = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_AXES    = 3;

  // sqrt(0.5) in Q0.16; the product with a count difference is scaled to Q1.15 by the shift.
  localparam logic [15:0] SQRT_HALF_Q16 = 16'd46341;
  localparam int SUN_SHIFT   = 11;
  localparam int RATE_SHIFT  = 20;
  localparam int ANGLE_SHIFT = 15;

  // Pipeline depths.
  localparam int SUN_LAT      = 3;
  localparam int AXIS_LAT     = 4;
  localparam int SQRT_STAGES  = 8;
  localparam int SQRT_STEPS   = SUN_W / SQRT_STAGES;
  localparam int SUNY_LAT     = 2 + SQRT_STAGES;
  localparam int PIPE_LAT     = SUN_LAT + SUNY_LAT;
  localparam int TORQUE_DELAY = SUNY_LAT - AXIS_LAT;

  // Register map.
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_GAIN_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_GAIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_GAIN_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN_Y     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN_Z     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ILLUM_THRESHOLD  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_ROLL_RATE = 3'd7;

  localparam logic [COUNT_W-1:0]       THRESHOLD_RESET   = 10'd204;
  localparam logic signed [RATE_W-1:0] SEARCH_RATE_RESET = 32'sd2534;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque_x;
    logic signed [TORQUE_W-1:0] torque_y;
    logic signed [TORQUE_W-1:0] torque_z;
    logic                       sun_valid;
    logic signed [SUN_W-1:0]    sun_x;
    logic [SUNY_W-1:0]          sun_y;
    logic signed [SUN_W-1:0]    sun_z;
  } result_t;

endpackage

`default_nettype wire

@@ design/sun_pointing_pd_attitude_law_top.sv @@
// Sun-pointing PD attitude law: takes one request of four sun sensor counts and three body
// rates per clock while in_ready is high and returns the three saturated wheel torques with
// the sun vector. The depth is set by the sun vector (three stages), the squares and argument
// clamp (two stages) and the eight-stage square root that resolves two bits of sun y per
// stage; the three axis lanes run alongside the root and their torques are delayed to meet it.
// A two-entry output register keeps in_ready independent of out_ready. Configuration is always
// ready; it must be written by the user only while the block is idle, which is not enforced.
`default_nettype none

module sun_pointing_pd_attitude_law_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [sppd_pkg::COUNT_W-1:0]             sun_count_px,
  input  logic [sppd_pkg::COUNT_W-1:0]             sun_count_pz,
  input  logic [sppd_pkg::COUNT_W-1:0]             sun_count_nx,
  input  logic [sppd_pkg::COUNT_W-1:0]             sun_count_nz,
  input  logic signed [sppd_pkg::RATE_W-1:0]       body_rate_x,
  input  logic signed [sppd_pkg::RATE_W-1:0]       body_rate_y,
  input  logic signed [sppd_pkg::RATE_W-1:0]       body_rate_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [sppd_pkg::TORQUE_W-1:0]     wheel_torque_x,
  output logic signed [sppd_pkg::TORQUE_W-1:0]     wheel_torque_y,
  output logic signed [sppd_pkg::TORQUE_W-1:0]     wheel_torque_z,
  output logic                                     sun_valid,
  output logic signed [sppd_pkg::SUN_W-1:0]        sun_vec_x,
  output logic [sppd_pkg::SUNY_W-1:0]              sun_vec_y,
  output logic signed [sppd_pkg::SUN_W-1:0]        sun_vec_z,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sppd_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [sppd_pkg::CFG_DATA_W-1:0]          cfg_data
);

`include "sun_pointing_pd_attitude_law_top_macros.svh"

  localparam int NA = sppd_pkg::NUM_AXES;

  logic [sppd_pkg::GAIN_W-1:0]          rate_gain  [NA];
  logic [sppd_pkg::GAIN_W-1:0]          angle_gain [NA];
  logic [sppd_pkg::COUNT_W-1:0]         illum_threshold;
  logic signed [sppd_pkg::RATE_W-1:0]   search_roll_rate;

  logic                                 en;
  logic [sppd_pkg::PIPE_LAT-1:0]        vld;
  logic                                 illum;
  logic signed [sppd_pkg::RATE_W-1:0]   rate_in  [NA];
  logic signed [sppd_pkg::RATE_W-1:0]   rate_q   [sppd_pkg::SUN_LAT][NA];
  logic                                 flag_q   [sppd_pkg::PIPE_LAT];
  logic signed [sppd_pkg::SUN_W-1:0]    sun_x_raw;
  logic signed [sppd_pkg::SUN_W-1:0]    sun_z_raw;
  logic [sppd_pkg::SUNY_W-1:0]          sun_y_raw;
  logic signed [sppd_pkg::SUN_W-1:0]    sunx_q   [sppd_pkg::SUNY_LAT];
  logic signed [sppd_pkg::SUN_W-1:0]    sunz_q   [sppd_pkg::SUNY_LAT];
  logic signed [sppd_pkg::RATE_W-1:0]   target   [NA];
  logic signed [sppd_pkg::SUN_W-1:0]    err      [NA];
  logic signed [sppd_pkg::TORQUE_W-1:0] torque_raw [NA];
  logic signed [sppd_pkg::TORQUE_W-1:0] tq_q     [sppd_pkg::TORQUE_DELAY][NA];
  logic                                 tail_valid;
  sppd_pkg::result_t                    tail_res;
  sppd_pkg::result_t                    out_q;
  sppd_pkg::result_t                    skid_q;
  logic                                 skid_valid;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        rate_gain[a]  <= '0;
        angle_gain[a] <= '0;
      end
      illum_threshold  <= sppd_pkg::THRESHOLD_RESET;
      search_roll_rate <= sppd_pkg::SEARCH_RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sppd_pkg::REG_RATE_GAIN_X:      rate_gain[0]  <= cfg_data;
        sppd_pkg::REG_RATE_GAIN_Y:      rate_gain[1]  <= cfg_data;
        sppd_pkg::REG_RATE_GAIN_Z:      rate_gain[2]  <= cfg_data;
        sppd_pkg::REG_ANGLE_GAIN_X:     angle_gain[0] <= cfg_data;
        sppd_pkg::REG_ANGLE_GAIN_Y:     angle_gain[1] <= cfg_data;
        sppd_pkg::REG_ANGLE_GAIN_Z:     angle_gain[2] <= cfg_data;
        sppd_pkg::REG_ILLUM_THRESHOLD:  illum_threshold <= cfg_data[sppd_pkg::COUNT_W-1:0];
        sppd_pkg::REG_SEARCH_ROLL_RATE: search_roll_rate <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances together; it only holds while the skid entry is occupied.
  assign en       = !skid_valid;
  assign in_ready = en;

  assign illum = (sun_count_px > illum_threshold) || (sun_count_pz > illum_threshold) ||
                 (sun_count_nx > illum_threshold) || (sun_count_nz > illum_threshold);

  assign rate_in[0] = body_rate_x;
  assign rate_in[1] = body_rate_y;
  assign rate_in[2] = body_rate_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[sppd_pkg::PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_q[0] <= illum;
      for (int k = 1; k < sppd_pkg::PIPE_LAT; k++) begin
        flag_q[k] <= flag_q[k-1];
      end
      for (int a = 0; a < NA; a++) begin
        rate_q[0][a] <= rate_in[a];
        for (int k = 1; k < sppd_pkg::SUN_LAT; k++) begin
          rate_q[k][a] <= rate_q[k-1][a];
        end
      end
      sunx_q[0] <= sun_x_raw;
      sunz_q[0] <= sun_z_raw;
      for (int k = 1; k < sppd_pkg::SUNY_LAT; k++) begin
        sunx_q[k] <= sunx_q[k-1];
        sunz_q[k] <= sunz_q[k-1];
      end
      for (int a = 0; a < NA; a++) begin
        tq_q[0][a] <= torque_raw[a];
        for (int k = 1; k < sppd_pkg::TORQUE_DELAY; k++) begin
          tq_q[k][a] <= tq_q[k-1][a];
        end
      end
    end
  end

  sppd_sun_lane u_sun_x (
    .clk       (clk),
    .en        (en),
    .count_pos (sun_count_px),
    .count_neg (sun_count_nx),
    .comp      (sun_x_raw)
  );

  sppd_sun_lane u_sun_z (
    .clk       (clk),
    .en        (en),
    .count_pos (sun_count_pz),
    .count_neg (sun_count_nz),
    .comp      (sun_z_raw)
  );

  sppd_sun_y u_sun_y (
    .clk   (clk),
    .en    (en),
    .sun_x (sun_x_raw),
    .sun_z (sun_z_raw),
    .sun_y (sun_y_raw)
  );

  // With the sun in view the law points at it; without, it rolls about x at the search rate.
  always_comb begin
    target[0] = flag_q[sppd_pkg::SUN_LAT-1] ? '0 : search_roll_rate;
    target[1] = '0;
    target[2] = '0;
    err[0]    = flag_q[sppd_pkg::SUN_LAT-1] ? -sun_z_raw : '0;
    err[1]    = '0;
    err[2]    = flag_q[sppd_pkg::SUN_LAT-1] ? sun_x_raw : '0;
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    sppd_axis_lane u_axis (
      .clk        (clk),
      .en         (en),
      .rate       (rate_q[sppd_pkg::SUN_LAT-1][a]),
      .target     (target[a]),
      .err        (err[a]),
      .rate_gain  (rate_gain[a]),
      .angle_gain (angle_gain[a]),
      .torque     (torque_raw[a])
    );
  end

  // Merge the lanes into one result.
  assign tail_valid = vld[sppd_pkg::PIPE_LAT-1];

  always_comb begin
    tail_res.torque_x  = tq_q[sppd_pkg::TORQUE_DELAY-1][0];
    tail_res.torque_y  = tq_q[sppd_pkg::TORQUE_DELAY-1][1];
    tail_res.torque_z  = tq_q[sppd_pkg::TORQUE_DELAY-1][2];
    tail_res.sun_valid = flag_q[sppd_pkg::PIPE_LAT-1];
    tail_res.sun_x     = sunx_q[sppd_pkg::SUNY_LAT-1];
    tail_res.sun_y     = sun_y_raw;
    tail_res.sun_z     = sunz_q[sppd_pkg::SUNY_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (tail_valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (tail_valid) begin
      if (!out_valid || out_ready) begin
        out_q <= tail_res;
      end else begin
        skid_q <= tail_res;
      end
    end
  end

  assign wheel_torque_x = out_q.torque_x;
  assign wheel_torque_y = out_q.torque_y;
  assign wheel_torque_z = out_q.torque_z;
  assign sun_valid      = out_q.sun_valid;
  assign sun_vec_x      = out_q.sun_x;
  assign sun_vec_y      = out_q.sun_y;
  assign sun_vec_z      = out_q.sun_z;

  `SPPD_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid entry full with output empty")
  `SPPD_ASSERT_IMPL(a_skid_fill_cause, $rose(skid_valid), $past(out_valid && !out_ready), "skid filled without a stalled output")
  `SPPD_ASSERT_NEXT(a_tail_kept_in_stall, tail_valid && skid_valid, tail_valid, "pipeline result lost during a stall")

endmodule

`default_nettype wire

@@ design/sppd_sun_lane.sv @@
`default_nettype none

module sppd_sun_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [sppd_pkg::COUNT_W-1:0]        count_pos,
  input  logic [sppd_pkg::COUNT_W-1:0]        count_neg,
  output logic signed [sppd_pkg::SUN_W-1:0]   comp
);

  localparam int DIFF_W = sppd_pkg::COUNT_W + 1;
  localparam int PROD_W = sppd_pkg::COUNT_W + 16;
  localparam int RND_W  = PROD_W + 1;
  localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (sppd_pkg::SUN_SHIFT - 1);

  logic signed [DIFF_W-1:0]          diff;
  logic [sppd_pkg::COUNT_W-1:0]      mag_next;
  logic [sppd_pkg::COUNT_W-1:0]      mag;
  logic                              neg1;
  logic                              neg2;
  logic [PROD_W-1:0]                 prod;
  logic [RND_W-1:0]                  rnd_sum;
  logic [sppd_pkg::SUN_W-1:0]        rnd;

  always_comb begin
    diff     = $signed({1'b0, count_pos}) - $signed({1'b0, count_neg});
    mag_next = diff[DIFF_W-1] ? sppd_pkg::COUNT_W'(-diff) : sppd_pkg::COUNT_W'(diff);
    rnd_sum  = {1'b0, prod} + HALF_LSB;
    rnd      = rnd_sum[sppd_pkg::SUN_SHIFT +: sppd_pkg::SUN_W];
  end

  // Rounding is done on the magnitude so that halves go away from zero.
  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= mag_next;
      neg1 <= diff[DIFF_W-1];
      prod <= PROD_W'(mag) * PROD_W'(sppd_pkg::SQRT_HALF_Q16);
      neg2 <= neg1;
      comp <= neg2 ? -$signed(rnd) : $signed(rnd);
    end
  end

endmodule

`default_nettype wire

@@ design/sppd_sun_y.sv @@
`default_nettype none

module sppd_sun_y (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sppd_pkg::SUN_W-1:0]  sun_x,
  input  logic signed [sppd_pkg::SUN_W-1:0]  sun_z,
  output logic [sppd_pkg::SUNY_W-1:0]        sun_y
);

  localparam int SQ_W = 2 * sppd_pkg::SUN_W;
  localparam int NS   = sppd_pkg::SQRT_STAGES;
  localparam int NJ   = sppd_pkg::SQRT_STEPS;
  localparam logic signed [SQ_W:0] ONE_Q30 = (SQ_W + 1)'(1) << (2 * (sppd_pkg::SUN_W - 1));
  localparam logic [SQ_W-1:0] Y_MAX = SQ_W'({sppd_pkg::SUNY_W{1'b1}});

  logic signed [SQ_W-1:0] sq_x;
  logic signed [SQ_W-1:0] sq_z;
  logic signed [SQ_W:0]   arg_diff;
  logic [SQ_W-1:0]        arg_next;
  logic [SQ_W-1:0]        rem_q  [NS];
  logic [SQ_W-1:0]        root_q [NS+1];
  logic [SQ_W-1:0]        rem_n  [NS];
  logic [SQ_W-1:0]        root_n [NS];
  logic [SQ_W-1:0]        r;
  logic [SQ_W-1:0]        q;
  logic [SQ_W-1:0]        b;
  logic [SQ_W-1:0]        t;

  always_comb begin
    arg_diff = ONE_Q30 - (SQ_W + 1)'(sq_x) - (SQ_W + 1)'(sq_z);
    // A negative argument is clamped, so the root comes out as zero.
    arg_next = arg_diff[SQ_W] ? '0 : arg_diff[SQ_W-1:0];
  end

  // Digit-by-digit square root, two result bits per pipeline stage.
  always_comb begin
    r = '0;
    q = '0;
    b = '0;
    t = '0;
    for (int s = 0; s < NS; s++) begin
      r = rem_q[s];
      q = root_q[s];
      for (int j = 0; j < NJ; j++) begin
        b = SQ_W'(1) << (SQ_W - 2 - 2 * (s * NJ + j));
        t = q + b;
        if (r >= t) begin
          r = r - t;
          q = (q >> 1) + b;
        end else begin
          q = q >> 1;
        end
      end
      rem_n[s]  = r;
      root_n[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x      <= sun_x * sun_x;
      sq_z      <= sun_z * sun_z;
      rem_q[0]  <= arg_next;
      root_q[0] <= '0;
      for (int s = 0; s < NS - 1; s++) begin
        rem_q[s+1] <= rem_n[s];
      end
      for (int s = 0; s < NS; s++) begin
        root_q[s+1] <= root_n[s];
      end
    end
  end

  // The root of exactly one does not fit Q1.15 and saturates.
  assign sun_y = (root_q[NS] > Y_MAX) ? '1 : root_q[NS][sppd_pkg::SUNY_W-1:0];

endmodule

`default_nettype wire

@@ design/sppd_axis_lane.sv @@
`default_nettype none

module sppd_axis_lane (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [sppd_pkg::RATE_W-1:0]    rate,
  input  logic signed [sppd_pkg::RATE_W-1:0]    target,
  input  logic signed [sppd_pkg::SUN_W-1:0]     err,
  input  logic [sppd_pkg::GAIN_W-1:0]           rate_gain,
  input  logic [sppd_pkg::GAIN_W-1:0]           angle_gain,
  output logic signed [sppd_pkg::TORQUE_W-1:0]  torque
);

  localparam int DIFF_W = sppd_pkg::RATE_W + 1;
  localparam int PR_W   = sppd_pkg::GAIN_W + sppd_pkg::RATE_W;
  localparam int PE_W   = sppd_pkg::GAIN_W + sppd_pkg::SUN_W;
  localparam int RR_W   = PR_W + 1 - sppd_pkg::RATE_SHIFT;
  localparam int RE_W   = PE_W + 1 - sppd_pkg::ANGLE_SHIFT;
  localparam int TR_W   = RR_W + 1;
  localparam int TE_W   = RE_W + 1;
  localparam int SUM_W  = TR_W + 1;
  localparam logic [PR_W:0] HALF_R = (PR_W + 1)'(1) << (sppd_pkg::RATE_SHIFT - 1);
  localparam logic [PE_W:0] HALF_E = (PE_W + 1)'(1) << (sppd_pkg::ANGLE_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] T_MAX =
    SUM_W'({1'b0, {(sppd_pkg::TORQUE_W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] T_MIN = -T_MAX - SUM_W'(1);

  logic signed [DIFF_W-1:0]      diff;
  logic [sppd_pkg::RATE_W-1:0]   mag_r_next;
  logic [sppd_pkg::SUN_W-1:0]    mag_e_next;
  logic [sppd_pkg::RATE_W-1:0]   mag_r;
  logic [sppd_pkg::SUN_W-1:0]    mag_e;
  logic                          neg_r1;
  logic                          neg_e1;
  logic                          neg_r2;
  logic                          neg_e2;
  logic [PR_W-1:0]               prod_r;
  logic [PE_W-1:0]               prod_e;
  logic [PR_W:0]                 sum_r;
  logic [PE_W:0]                 sum_e;
  logic [RR_W-1:0]               rnd_r;
  logic [RE_W-1:0]               rnd_e;
  logic signed [TR_W-1:0]        term_r;
  logic signed [TE_W-1:0]        term_e;
  logic signed [SUM_W-1:0]       total;

  always_comb begin
    diff       = DIFF_W'(rate) - DIFF_W'(target);
    // The rate difference never reaches 2^32 in magnitude, so 32 bits hold it.
    mag_r_next = diff[DIFF_W-1] ? sppd_pkg::RATE_W'(-diff) : sppd_pkg::RATE_W'(diff);
    mag_e_next = err[sppd_pkg::SUN_W-1] ? sppd_pkg::SUN_W'(-err) : sppd_pkg::SUN_W'(err);
    sum_r      = {1'b0, prod_r} + HALF_R;
    sum_e      = {1'b0, prod_e} + HALF_E;
    rnd_r      = sum_r[PR_W:sppd_pkg::RATE_SHIFT];
    rnd_e      = sum_e[PE_W:sppd_pkg::ANGLE_SHIFT];
    total      = SUM_W'(term_r) + SUM_W'(term_e);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_r_next;
      mag_e  <= mag_e_next;
      neg_r1 <= diff[DIFF_W-1];
      neg_e1 <= err[sppd_pkg::SUN_W-1];
      prod_r <= rate_gain * mag_r;
      prod_e <= angle_gain * mag_e;
      neg_r2 <= neg_r1;
      neg_e2 <= neg_e1;
      term_r <= neg_r2 ? -$signed({1'b0, rnd_r}) : $signed({1'b0, rnd_r});
      term_e <= neg_e2 ? -$signed({1'b0, rnd_e}) : $signed({1'b0, rnd_e});
      if (total > T_MAX) begin
        torque <= T_MAX[sppd_pkg::TORQUE_W-1:0];
      end else if (total < T_MIN) begin
        torque <= T_MIN[sppd_pkg::TORQUE_W-1:0];
      end else begin
        torque <= total[sppd_pkg::TORQUE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_sun_pointing_pd_attitude_law_top.sv @@
`timescale 1ns / 100ps

module tb_sun_pointing_pd_attitude_law_top;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [sppd_pkg::COUNT_W-1:0]       px;
    logic [sppd_pkg::COUNT_W-1:0]       pz;
    logic [sppd_pkg::COUNT_W-1:0]       nx;
    logic [sppd_pkg::COUNT_W-1:0]       nz;
    logic signed [sppd_pkg::RATE_W-1:0] rx;
    logic signed [sppd_pkg::RATE_W-1:0] ry;
    logic signed [sppd_pkg::RATE_W-1:0] rz;
  } sample_t;

  // Mirrors the law's registers, predicts each torque command and holds the ones still due.
  class torque_ledger;
    logic [31:0]           rate_gain [3];
    logic [31:0]           angle_gain [3];
    logic [9:0]            threshold;
    longint                search_rate;
    sppd_pkg::result_t     pending_cmds [$];
    int                    mismatches;

    function new();
      for (int i = 0; i < 3; i++) begin
        rate_gain[i] = '0;
        angle_gain[i] = '0;
      end
      threshold = sppd_pkg::THRESHOLD_RESET;
      search_rate = sppd_pkg::SEARCH_RATE_RESET;
      mismatches = 0;
    endfunction

    function void note_reg(logic [sppd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        sppd_pkg::REG_RATE_GAIN_X:      rate_gain[0] = data;
        sppd_pkg::REG_RATE_GAIN_Y:      rate_gain[1] = data;
        sppd_pkg::REG_RATE_GAIN_Z:      rate_gain[2] = data;
        sppd_pkg::REG_ANGLE_GAIN_X:     angle_gain[0] = data;
        sppd_pkg::REG_ANGLE_GAIN_Y:     angle_gain[1] = data;
        sppd_pkg::REG_ANGLE_GAIN_Z:     angle_gain[2] = data;
        sppd_pkg::REG_ILLUM_THRESHOLD:  threshold = data[9:0];
        sppd_pkg::REG_SEARCH_ROLL_RATE: search_rate = $signed(data);
        default: ;
      endcase
    endfunction

    // Opposing-sensor difference times sqrt(0.5), rounded half away from zero, in Q1.15.
    function longint sun_axis(logic [9:0] a, logic [9:0] b);
      longint d;
      longint mag;
      d = longint'(a) - longint'(b);
      mag = (d < 0) ? -d : d;
      mag = (mag * 46341 + 1024) >>> 11;
      return (d < 0) ? -mag : mag;
    endfunction

    function longint gain_term(logic [31:0] gain, longint val, int sh);
      logic [63:0] mag;
      logic [63:0] prod;
      mag = (val < 0) ? 64'(-val) : 64'(val);
      prod = {32'b0, gain} * mag;
      prod = (prod + (64'd1 << (sh - 1))) >> sh;
      return (val < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function longint root_floor(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function sppd_pkg::result_t predict_command(sample_t s);
      sppd_pkg::result_t r;
      longint sx, sz, arg, sy, t;
      longint rate [3];
      longint target [3];
      longint err [3];
      logic [31:0] torque [3];
      bit lit;
      lit = (s.px > threshold) || (s.pz > threshold) ||
            (s.nx > threshold) || (s.nz > threshold);
      sx = sun_axis(s.px, s.nx);
      sz = sun_axis(s.pz, s.nz);
      arg = (longint'(1) << 30) - sx * sx - sz * sz;
      if (arg < 0) arg = 0;
      sy = root_floor(arg);
      if (sy > 32767) sy = 32767;
      rate[0] = s.rx;
      rate[1] = s.ry;
      rate[2] = s.rz;
      target[1] = 0;
      target[2] = 0;
      err[1] = 0;
      if (lit) begin
        target[0] = 0;
        err[0] = -sz;
        err[2] = sx;
      end else begin
        target[0] = search_rate;
        err[0] = 0;
        err[2] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        t = gain_term(rate_gain[i], rate[i] - target[i], 20) +
            gain_term(angle_gain[i], err[i], 15);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        torque[i] = 32'(t);
      end
      r.torque_x = torque[0];
      r.torque_y = torque[1];
      r.torque_z = torque[2];
      r.sun_valid = lit;
      r.sun_x = 16'(sx);
      r.sun_y = 15'(sy);
      r.sun_z = 16'(sz);
      return r;
    endfunction

    function void note_sample(sample_t s);
      pending_cmds.push_back(predict_command(s));
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_command(sppd_pkg::result_t got);
      sppd_pkg::result_t want;
      if (pending_cmds.size() == 0) begin
        report("torque command with no request outstanding");
        return;
      end
      want = pending_cmds.pop_front();
      if (got.torque_x !== want.torque_x)
        report($sformatf("torque_x got %0d want %0d", got.torque_x, want.torque_x));
      if (got.torque_y !== want.torque_y)
        report($sformatf("torque_y got %0d want %0d", got.torque_y, want.torque_y));
      if (got.torque_z !== want.torque_z)
        report($sformatf("torque_z got %0d want %0d", got.torque_z, want.torque_z));
      if (got.sun_valid !== want.sun_valid)
        report($sformatf("sun_valid got %0b want %0b", got.sun_valid, want.sun_valid));
      if (got.sun_x !== want.sun_x)
        report($sformatf("sun_x got %0d want %0d", got.sun_x, want.sun_x));
      if (got.sun_y !== want.sun_y)
        report($sformatf("sun_y got %0d want %0d", got.sun_y, want.sun_y));
      if (got.sun_z !== want.sun_z)
        report($sformatf("sun_z got %0d want %0d", got.sun_z, want.sun_z));
    endtask
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [sppd_pkg::COUNT_W-1:0]         sun_count_px;
  logic [sppd_pkg::COUNT_W-1:0]         sun_count_pz;
  logic [sppd_pkg::COUNT_W-1:0]         sun_count_nx;
  logic [sppd_pkg::COUNT_W-1:0]         sun_count_nz;
  logic signed [sppd_pkg::RATE_W-1:0]   body_rate_x;
  logic signed [sppd_pkg::RATE_W-1:0]   body_rate_y;
  logic signed [sppd_pkg::RATE_W-1:0]   body_rate_z;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [sppd_pkg::TORQUE_W-1:0] wheel_torque_x;
  logic signed [sppd_pkg::TORQUE_W-1:0] wheel_torque_y;
  logic signed [sppd_pkg::TORQUE_W-1:0] wheel_torque_z;
  logic                                 sun_valid;
  logic signed [sppd_pkg::SUN_W-1:0]    sun_vec_x;
  logic [sppd_pkg::SUNY_W-1:0]          sun_vec_y;
  logic signed [sppd_pkg::SUN_W-1:0]    sun_vec_z;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [sppd_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [sppd_pkg::CFG_DATA_W-1:0]      cfg_data;

  torque_ledger ledger = new();
  bit           steady = 1'b0;
  int           idle_cycles = 0;

  sun_pointing_pd_attitude_law_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sun_count_px   (sun_count_px),
    .sun_count_pz   (sun_count_pz),
    .sun_count_nx   (sun_count_nx),
    .sun_count_nz   (sun_count_nz),
    .body_rate_x    (body_rate_x),
    .body_rate_y    (body_rate_y),
    .body_rate_z    (body_rate_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .wheel_torque_x (wheel_torque_x),
    .wheel_torque_y (wheel_torque_y),
    .wheel_torque_z (wheel_torque_z),
    .sun_valid      (sun_valid),
    .sun_vec_x      (sun_vec_x),
    .sun_vec_y      (sun_vec_y),
    .sun_vec_z      (sun_vec_z),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_command(sppd_pkg::result_t'({wheel_torque_x, wheel_torque_y, wheel_torque_z,
                                                sun_valid, sun_vec_x, sun_vec_y, sun_vec_z}));
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL sun_pointing_pd_attitude_law_top");
    $finish;
  end

  function automatic sample_t mk(int px, int pz, int nx, int nz,
                                 logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    sample_t s;
    s.px = 10'(px);
    s.pz = 10'(pz);
    s.nx = 10'(nx);
    s.nz = 10'(nz);
    s.rx = rx;
    s.ry = ry;
    s.rz = rz;
    return s;
  endfunction

  // Counts lean towards the threshold edge and the ends of the range.
  function automatic logic [9:0] pick_count();
    int thr;
    thr = ledger.threshold;
    case ($urandom_range(0, 4))
      0: return 10'($urandom_range(thr > 0 ? thr - 1 : 0, thr < 1023 ? thr + 1 : 1023));
      1: return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 8191)) - 4096);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s = mk(pick_count(), pick_count(), pick_count(), pick_count(),
           pick_rate(), pick_rate(), pick_rate());
    if ($urandom_range(0, 5) == 0) s.nx = s.px;
    if ($urandom_range(0, 5) == 0) s.nz = s.pz;
    return s;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_sample(sample_t s);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    sun_count_px <= s.px;
    sun_count_pz <= s.pz;
    sun_count_nx <= s.nx;
    sun_count_nz <= s.nz;
    body_rate_x  <= s.rx;
    body_rate_y  <= s.ry;
    body_rate_z  <= s.rz;
    do @(posedge clk); while (!in_ready);
    ledger.note_sample(s);
    @(negedge clk);
  endtask

  task automatic run_phase(int n);
    repeat (n) send_sample(random_sample());
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [sppd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.note_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_law(logic [31:0] kr_x, logic [31:0] kr_y, logic [31:0] kr_z,
                         logic [31:0] kp_x, logic [31:0] kp_y, logic [31:0] kp_z,
                         logic [9:0] thr, logic [31:0] search);
    write_reg(sppd_pkg::REG_RATE_GAIN_X, kr_x);
    write_reg(sppd_pkg::REG_RATE_GAIN_Y, kr_y);
    write_reg(sppd_pkg::REG_RATE_GAIN_Z, kr_z);
    write_reg(sppd_pkg::REG_ANGLE_GAIN_X, kp_x);
    write_reg(sppd_pkg::REG_ANGLE_GAIN_Y, kp_y);
    write_reg(sppd_pkg::REG_ANGLE_GAIN_Z, kp_z);
    write_reg(sppd_pkg::REG_ILLUM_THRESHOLD, {22'b0, thr});
    write_reg(sppd_pkg::REG_SEARCH_ROLL_RATE, search);
    cfg_valid <= 1'b0;
  endtask

  // Registers may only change once the pipeline has emptied.
  task automatic drain();
    while (ledger.pending_cmds.size() != 0) @(negedge clk);
    repeat (sppd_pkg::PIPE_LAT + 4) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sun_count_px = '0;
    sun_count_pz = '0;
    sun_count_nx = '0;
    sun_count_nz = '0;
    body_rate_x = '0;
    body_rate_y = '0;
    body_rate_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: zero gains, so only the sun vector and the threshold edge show.
    send_sample(mk(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1));
    send_sample(mk(204, 204, 204, 204, 32'h0, 32'h0, 32'h0));
    send_sample(mk(0, 205, 0, 0, 32'hffff_ffff, 32'h10, 32'h0));
    in_valid <= 1'b0;
    drain();

    set_law(32'h0100_0000, 32'h0080_0000, 32'h0300_0000,
            32'h0100_0000, 32'h0040_0000, 32'h0200_0000, 10'd204, 32'hffff_f000);
    send_sample(mk(0, 0, 0, 0, 32'h0, 32'h0, 32'h0));
    send_sample(mk(0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    send_sample(mk(1023, 1023, 1023, 1023, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    send_sample(mk(1023, 1023, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
    send_sample(mk(0, 0, 1023, 1023, 32'h7fff_ffff, 32'h0, 32'h8000_0000));
    send_sample(mk(1023, 0, 0, 1023, 32'h1, 32'hffff_ffff, 32'h1));
    send_sample(mk(205, 0, 0, 0, 32'h0, 32'h0, 32'h0));
    send_sample(mk(0, 205, 0, 0, 32'h0, 32'h0, 32'h0));
    send_sample(mk(0, 0, 205, 0, 32'h0, 32'h0, 32'h0));
    send_sample(mk(0, 0, 0, 205, 32'h0, 32'h0, 32'h0));
    send_sample(mk(204, 204, 204, 204, 32'h1000, 32'hffff_f000, 32'h0));
    send_sample(mk(500, 700, 500, 700, 32'h0, 32'h0, 32'h0));
    send_sample(mk(1, 0, 0, 3, 32'hffff_ffff, 32'h1, 32'hffff_ffff));
    send_sample(mk(100, 3, 3, 100, 32'h0000_1234, 32'h0, 32'hffff_edcc));
    send_sample(mk(900, 311, 17, 640, 32'h0, 32'h0, 32'h0));
    in_valid <= 1'b0;
    drain();

    set_law($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
            $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
            10'($urandom_range(100, 600)), $urandom);
    run_phase(150);
    drain();

    // Largest gains with the sun never seen: the search rate drives the x lane.
    set_law(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 10'd1023, 32'h7fff_ffff);
    run_phase(150);
    drain();

    set_law(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 32'h8000_0000);
    run_phase(120);
    drain();

    steady = 1'b1;
    set_law($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            10'($urandom_range(0, 1023)), $urandom);
    run_phase(180);
    drain();
    steady = 1'b0;

    set_law(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 10'd0, 32'h8000_0000);
    run_phase(150);
    drain();

    if (ledger.mismatches == 0)
      $display("PASS sun_pointing_pd_attitude_law_top");
    else
      $display("FAIL sun_pointing_pd_attitude_law_top");
    $finish;
  end

endmodule
